[hdl/mqttrx_pkg.sv]
`timescale 1ns / 1ps

package mqttrx_pkg;

	// result kinds
	typedef enum logic [3:0] {
		KIND_TOPIC      = 4'd0,
		KIND_MESSAGE    = 4'd1,
		KIND_CONNACK    = 4'd2,
		KIND_PUB_DONE   = 4'd3,
		KIND_SEND_REL   = 4'd4,
		KIND_SEND_COMP  = 4'd5,
		KIND_ACK        = 4'd6,
		KIND_LINK_LOST  = 4'd7,
		KIND_SHUTDOWN   = 4'd8,
		KIND_MALFORMED  = 4'd9
	} kind_t;

	// parse phases
	typedef enum logic [3:0] {
		PH_HEADER  = 4'd0,
		PH_LENGTH  = 4'd1,
		PH_BODY    = 4'd2,
		PH_TLEN_HI = 4'd3,
		PH_TLEN_LO = 4'd4,
		PH_TOPIC   = 4'd5,
		PH_MID_HI  = 4'd6,
		PH_MID_LO  = 4'd7,
		PH_MSG     = 4'd8
	} phase_t;

	// control packet types
	localparam logic [3:0] PT_RESERVED0 = 4'd0;
	localparam logic [3:0] PT_CONNACK   = 4'd2;
	localparam logic [3:0] PT_PUBLISH   = 4'd3;
	localparam logic [3:0] PT_PUBACK    = 4'd4;
	localparam logic [3:0] PT_PUBREC    = 4'd5;
	localparam logic [3:0] PT_PUBREL    = 4'd6;
	localparam logic [3:0] PT_PUBCOMP   = 4'd7;
	localparam logic [3:0] PT_SUBACK    = 4'd9;
	localparam logic [3:0] PT_UNSUBACK  = 4'd11;
	localparam logic [3:0] PT_PINGREQ   = 4'd12;
	localparam logic [3:0] PT_RESERVED15 = 4'd15;

	// qos codes
	localparam logic [1:0] QOS_0 = 2'd0;
	localparam logic [1:0] QOS_1 = 2'd1;
	localparam logic [1:0] QOS_2 = 2'd2;

	// reply owed after a publish
	localparam logic [1:0] REPLY_NONE   = 2'd0;
	localparam logic [1:0] REPLY_PUBACK = 2'd1;
	localparam logic [1:0] REPLY_PUBREC = 2'd2;

	// operation codes
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_CONNECT = 1'b1;

	// modem message characters
	localparam logic [7:0] CHR_C    = 8'h43;
	localparam logic [7:0] CHR_L    = 8'h4C;
	localparam logic [7:0] CHR_PLUS = 8'h2B;
	localparam logic [7:0] CHR_P    = 8'h50;

	localparam int COUNT_W = 28;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [3:0]  packet_type;
		logic [1:0]  qos_level;
		logic [15:0] connack_value;
		logic        connack_ok;
		logic [15:0] message_id;
		logic [1:0]  reply_kind;
		logic        last;
	} res_t;

	function automatic res_t mk_res(kind_t k, logic [7:0] pay, logic [7:0] hdr,
			logic [15:0] conn, logic ok, logic [15:0] mid, logic [1:0] rk);
		res_t r;
		r.kind          = k;
		r.payload_byte  = pay;
		r.packet_type   = hdr[7:4];
		r.qos_level     = hdr[2:1];
		r.connack_value = conn;
		r.connack_ok    = ok;
		r.message_id    = mid;
		r.reply_kind    = rk;
		r.last          = 1'b0;
		return r;
	endfunction

endpackage

[hdl/mqttrx_parser.sv]
`timescale 1ns / 1ps

module mqttrx_parser #(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	input  logic               take,
	input  logic               operation,
	input  logic [7:0]         data,
	output logic [1:0]         res_cnt,
	output mqttrx_pkg::res_t   res0,
	output mqttrx_pkg::res_t   res1
);
	import mqttrx_pkg::*;

	logic               link_q, link_d;
	phase_t             phase_q, phase_d;
	logic [7:0]         hdr_q, hdr_d;
	logic [COUNT_W-1:0] rc_q, rc_d;
	logic [2:0]         idx_q, idx_d;
	logic [15:0]        tl_q, tl_d;
	logic [15:0]        ftb_q, ftb_d;
	logic [15:0]        mid_q, mid_d;

	logic [COUNT_W-1:0] len_add;
	logic               do_fin;
	logic               fin_ok;
	res_t               fin_r;
	res_t               r0, r1;
	logic [1:0]         n;
	logic [1:0]         rk;

	// length byte weight by position
	always_comb begin
		case (idx_q[1:0])
			2'd0:    len_add = {21'b0, data[6:0]};
			2'd1:    len_add = {14'b0, data[6:0], 7'b0};
			2'd2:    len_add = {7'b0, data[6:0], 14'b0};
			2'd3:    len_add = {data[6:0], 21'b0};
			default: len_add = '0;
		endcase
	end

	always_comb begin
		link_d  = link_q;
		phase_d = phase_q;
		hdr_d   = hdr_q;
		rc_d    = rc_q;
		idx_d   = idx_q;
		tl_d    = tl_q;
		ftb_d   = ftb_q;
		mid_d   = mid_q;
		r0      = '0;
		r1      = '0;
		n       = 2'd0;
		do_fin  = 1'b0;
		fin_ok  = 1'b0;
		fin_r   = '0;
		rk      = REPLY_NONE;

		if (operation == OP_CONNECT) begin
			link_d  = 1'b1;
			phase_d = PH_HEADER;
			rc_d    = '0;
			idx_d   = 3'd0;
		end else if (link_q) begin
			if (phase_q == PH_HEADER) begin
				if (data[7:4] != PT_RESERVED0 && data[7:4] != PT_RESERVED15) begin
					hdr_d   = data;
					rc_d    = '0;
					idx_d   = 3'd0;
					tl_d    = 16'd0;
					ftb_d   = 16'd0;
					mid_d   = 16'd0;
					phase_d = PH_LENGTH;
				end
			end else if (phase_q == PH_LENGTH) begin
				if (rc_q == '0 && ((hdr_q == CHR_C && data == CHR_L) ||
						(hdr_q == CHR_PLUS && data == CHR_P))) begin
					// modem text in the stream: link dropped
					link_d  = 1'b0;
					phase_d = PH_HEADER;
					r0      = mk_res(KIND_LINK_LOST, 8'd0, hdr_q, 16'd0, 1'b0, 16'd0,
						REPLY_NONE);
					n       = 2'd1;
				end else begin
					rc_d  = rc_q + len_add;
					idx_d = idx_q + 3'd1;
					if (data[7]) begin
						if (idx_d >= 3'(MAX_LENGTH_BYTES)) begin
							phase_d = PH_HEADER;
							r0      = mk_res(KIND_MALFORMED, 8'd0, hdr_q, 16'd0, 1'b0,
								16'd0, REPLY_NONE);
							n       = 2'd1;
						end
					end else begin
						idx_d   = 3'd0;
						phase_d = (hdr_q[7:4] == PT_PUBLISH) ? PH_TLEN_HI : PH_BODY;
						do_fin  = (rc_d == '0);
					end
				end
			end else if (phase_q inside {[PH_BODY:PH_MSG]}) begin
				rc_d = (rc_q != '0) ? rc_q - COUNT_W'(1) : rc_q;
				case (phase_q)
					PH_BODY: begin
						if (idx_q == 3'd0)
							ftb_d = {data, 8'd0};
						else if (idx_q == 3'd1)
							ftb_d = {ftb_q[15:8], data};
						if (idx_q < 3'd2)
							idx_d = idx_q + 3'd1;
					end
					PH_TLEN_HI: begin
						ftb_d   = {data, 8'd0};
						phase_d = PH_TLEN_LO;
					end
					PH_TLEN_LO: begin
						ftb_d = {ftb_q[15:8], data};
						tl_d  = ftb_d;
						if (tl_d != 16'd0)
							phase_d = PH_TOPIC;
						else
							phase_d = (hdr_q[2:1] != QOS_0) ? PH_MID_HI : PH_MSG;
					end
					PH_TOPIC: begin
						r0   = mk_res(KIND_TOPIC, data, hdr_q, 16'd0, 1'b0, 16'd0,
							REPLY_NONE);
						n    = 2'd1;
						tl_d = tl_q - 16'd1;
						if (tl_d == 16'd0)
							phase_d = (hdr_q[2:1] != QOS_0) ? PH_MID_HI : PH_MSG;
					end
					PH_MID_HI: begin
						mid_d   = {data, 8'd0};
						phase_d = PH_MID_LO;
					end
					PH_MID_LO: begin
						mid_d   = {mid_q[15:8], data};
						phase_d = PH_MSG;
					end
					PH_MSG: begin
						r0 = mk_res(KIND_MESSAGE, data, hdr_q, 16'd0, 1'b0, 16'd0,
							REPLY_NONE);
						n  = 2'd1;
					end
					default: ;
				endcase
				do_fin = (rc_d == '0);
			end else begin
				phase_d = PH_HEADER;
			end
		end

		// packet complete
		if (do_fin) begin
			phase_d = PH_HEADER;
			if (hdr_q[2:1] == QOS_1)
				rk = REPLY_PUBACK;
			else if (hdr_q[2:1] == QOS_2)
				rk = REPLY_PUBREC;
			case (hdr_q[7:4])
				PT_CONNACK: begin
					fin_r  = mk_res(KIND_CONNACK, 8'd0, hdr_q, ftb_d, ftb_d == 16'd0,
						16'd0, REPLY_NONE);
					fin_ok = 1'b1;
				end
				PT_PUBLISH: begin
					fin_r  = mk_res(KIND_PUB_DONE, 8'd0, hdr_q, 16'd0, 1'b0, mid_d, rk);
					fin_ok = 1'b1;
				end
				PT_PUBREC: begin
					fin_r  = mk_res(KIND_SEND_REL, 8'd0, hdr_q, 16'd0, 1'b0, ftb_d,
						REPLY_NONE);
					fin_ok = 1'b1;
				end
				PT_PUBREL: begin
					fin_r  = mk_res(KIND_SEND_COMP, 8'd0, hdr_q, 16'd0, 1'b0, ftb_d,
						REPLY_NONE);
					fin_ok = 1'b1;
				end
				PT_PUBACK, PT_PUBCOMP, PT_SUBACK, PT_UNSUBACK: begin
					fin_r  = mk_res(KIND_ACK, 8'd0, hdr_q, 16'd0, 1'b0, ftb_d,
						REPLY_NONE);
					fin_ok = 1'b1;
				end
				PT_PINGREQ: begin
					link_d = 1'b0;
					fin_r  = mk_res(KIND_SHUTDOWN, 8'd0, hdr_q, 16'd0, 1'b0, 16'd0,
						REPLY_NONE);
					fin_ok = 1'b1;
				end
				default: ;
			endcase
			if (fin_ok) begin
				if (n == 2'd0) begin
					r0 = fin_r;
					n  = 2'd1;
				end else begin
					r1 = fin_r;
					n  = 2'd2;
				end
			end
		end

		if (n == 2'd1)
			r0.last = 1'b1;
		if (n == 2'd2)
			r1.last = 1'b1;
	end

	assign res_cnt = valid ? n : 2'd0;
	assign res0    = r0;
	assign res1    = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q  <= 1'b0;
			phase_q <= PH_HEADER;
			hdr_q   <= 8'd0;
			rc_q    <= '0;
			idx_q   <= 3'd0;
			tl_q    <= 16'd0;
			ftb_q   <= 16'd0;
			mid_q   <= 16'd0;
		end else if (take) begin
			link_q  <= link_d;
			phase_q <= phase_d;
			hdr_q   <= hdr_d;
			rc_q    <= rc_d;
			idx_q   <= idx_d;
			tl_q    <= tl_d;
			ftb_q   <= ftb_d;
			mid_q   <= mid_d;
		end
	end

endmodule

[hdl/mqttrx_outq.sv]
`timescale 1ns / 1ps

module mqttrx_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_n,
	input  mqttrx_pkg::res_t push0,
	input  mqttrx_pkg::res_t push1,
	input  logic             result_ready,
	output logic [1:0]       room,
	output logic             result_valid,
	output mqttrx_pkg::res_t head
);
	import mqttrx_pkg::*;

	res_t       e0_q, e1_q;
	res_t       e0_d, e1_d;
	logic [1:0] cnt_q, cnt_d;
	logic [1:0] cnt_pop;
	logic       pop;

	assign result_valid = (cnt_q != 2'd0);
	assign pop          = result_valid && result_ready;
	assign room         = 2'd2 - cnt_q + {1'b0, pop};
	assign head         = e0_q;

	always_comb begin
		cnt_pop = cnt_q - {1'b0, pop};
		e0_d    = pop ? e1_q : e0_q;
		e1_d    = e1_q;
		if (push_n != 2'd0) begin
			if (cnt_pop == 2'd0)
				e0_d = push0;
			else
				e1_d = push0;
		end
		if (push_n == 2'd2)
			e1_d = push1;
		cnt_d = cnt_pop + push_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else
			cnt_q <= cnt_d;
	end

	always_ff @(posedge clk) begin
		e0_q <= e0_d;
		e1_q <= e1_d;
	end

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_n <= room)
		else $error("push exceeds free slots");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == $past(cnt_q) - {1'b0, $past(pop)} + $past(push_n))
		else $error("queue count lost track of transfers");
`endif

endmodule

[hdl/mqtt_receive_packet_parser_top.sv]
`timescale 1ns / 1ps

// channel   signals                         direction  payload
// item      item_valid / item_ready         in         operation, data
// result    result_valid / result_ready     out        kind .. last (nine fields)
//
// one link byte is taken per cycle while the queue has room; it sits in the
// input register while the parse step runs; its results go to a two-entry queue
// the result port gives one transfer per cycle while result_ready is high, so a
// byte with two results (last publish byte with publish done) needs two transfers
// a byte leaves the input register only when the queue has room for its results
// arst_n clears link state (link down), parse phase and the queue

module mqtt_receive_packet_parser_top #(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        operation,
	input  logic [7:0]  data,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [3:0]  kind,
	output logic [7:0]  payload_byte,
	output logic [3:0]  packet_type,
	output logic [1:0]  qos_level,
	output logic [15:0] connack_value,
	output logic        connack_ok,
	output logic [15:0] message_id,
	output logic [1:0]  reply_kind,
	output logic        last
);
	import mqttrx_pkg::*;

	// input register
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] data_s1;

	logic [1:0] res_cnt;
	res_t       res0, res1;
	logic [1:0] room;
	logic       take;
	logic [1:0] push_n;
	res_t       head;

	// the byte in the input register commits when all its results fit
	assign take       = valid_s1 && (res_cnt <= room);
	assign push_n     = take ? res_cnt : 2'd0;
	assign item_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item_ready)
			valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			op_s1   <= operation;
			data_s1 <= data;
		end
	end

	mqttrx_parser #(
		.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid_s1),
		.take      (take),
		.operation (op_s1),
		.data      (data_s1),
		.res_cnt   (res_cnt),
		.res0      (res0),
		.res1      (res1)
	);

	mqttrx_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_n       (push_n),
		.push0        (res0),
		.push1        (res1),
		.result_ready (result_ready),
		.room         (room),
		.result_valid (result_valid),
		.head         (head)
	);

	// result fields straight from the queue head
	assign kind          = head.kind;
	assign payload_byte  = head.payload_byte;
	assign packet_type   = head.packet_type;
	assign qos_level     = head.qos_level;
	assign connack_value = head.connack_value;
	assign connack_ok    = head.connack_ok;
	assign message_id    = head.message_id;
	assign reply_kind    = head.reply_kind;
	assign last          = head.last;

endmodule
